// ----- rtl/dtth_pkg.sv -----
// ----------------------------------------------------------------------------
// dtth_pkg: shared types and constants for decimal text to hundredths
// Character codes, overflow limits, fraction counter codes and the result
// record handed from the parser to the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtth_pkg;

   // Character codes
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Whole part above this cannot take another digit without overflow
   localparam logic [62:0] DIGIT_LIMIT = 63'd922337203685477579;
   // Largest whole part whose hundredths still fit a signed 64-bit value
   localparam logic [62:0] WHOLE_LIMIT = 63'd92233720368547758;

   // Fraction counter codes
   localparam logic [1:0] FC_NONE  = 2'd0;  // no point yet
   localparam logic [1:0] FC_POINT = 2'd1;  // point seen, no fraction digit
   localparam logic [1:0] FC_ONE   = 2'd2;  // one fraction digit
   localparam logic [1:0] FC_TWO   = 2'd3;  // two fraction digits

   // Result of one end marker
   typedef struct packed {
      logic signed [63:0] amount;
      logic               error;
   } dtth_result_type;

endpackage

`default_nettype wire

// ----- rtl/dtth_parser.sv -----
// ----------------------------------------------------------------------------
// dtth_parser: per-character parse state and result formation
// Holds the running parse state, updates it for each consumed character
// beat, and forms the signed hundredths result for an end marker beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtth_parser
   import dtth_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,        // consume the presented beat
   input  wire logic [7:0]      char_code,
   input  wire logic            end_of_text,
   output dtth_result_type      result       // valid when end_of_text is set
);

   logic               at_start_ff,   at_start_in;
   logic               negative_ff,   negative_in;
   logic [1:0]         frac_count_ff, frac_count_in;
   logic               digit_seen_ff, digit_seen_in;
   logic [62:0]        whole_ff,      whole_in;
   logic signed [63:0] acc_ff,        acc_in;    // signed whole part times 100
   logic [6:0]         cents_ff,      cents_in;  // fraction in hundredths
   logic               sticky_ff,     sticky_in;

   logic [3:0]         digit;
   logic               is_digit;
   logic [9:0]         digit_x100;
   logic [63:0]        digit_term;
   logic [62:0]        whole_x10;
   logic [63:0]        acc_x10;
   logic [6:0]         digit_x10;
   logic [63:0]        cents_term;
   logic               end_error;

   assign digit      = 4'(char_code - CH_ZERO);
   assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign digit_x100 = 10'(digit * 10'd100);
   assign digit_x10  = 7'(digit * 7'd10);
   assign digit_term = negative_ff ? 64'(-{54'd0, digit_x100}) : {54'd0, digit_x100};
   assign whole_x10  = {whole_ff[59:0], 3'b000} + {whole_ff[61:0], 1'b0};
   assign acc_x10    = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0};

   // Next state for a character beat
   always_comb begin
      at_start_in   = at_start_ff;
      negative_in   = negative_ff;
      frac_count_in = frac_count_ff;
      digit_seen_in = digit_seen_ff;
      whole_in      = whole_ff;
      acc_in        = acc_ff;
      cents_in      = cents_ff;
      sticky_in     = sticky_ff;
      if (step && !end_of_text) begin
         at_start_in = 1'b0;
         if (sticky_ff) begin
            // drop characters until the end marker
         end else if (at_start_ff && char_code == CH_MINUS) begin
            negative_in = 1'b1;
         end else if (char_code == CH_POINT) begin
            if (frac_count_ff != FC_NONE) begin
               sticky_in = 1'b1;
            end else begin
               frac_count_in = FC_POINT;
            end
         end else if (!is_digit) begin
            sticky_in = 1'b1;
         end else begin
            digit_seen_in = 1'b1;
            case (frac_count_ff)
               FC_NONE: begin
                  if (whole_ff > DIGIT_LIMIT) begin
                     sticky_in = 1'b1;
                  end else begin
                     whole_in = whole_x10 + 63'(digit);
                     acc_in   = $signed(acc_x10 + digit_term);
                  end
               end
               FC_POINT: begin
                  cents_in      = digit_x10;
                  frac_count_in = FC_ONE;
               end
               FC_ONE: begin
                  cents_in      = cents_ff + 7'(digit);
                  frac_count_in = FC_TWO;
               end
               default: begin
                  sticky_in = 1'b1;
               end
            endcase
         end
      end
   end

   // Clear on reset and after each end marker
   always_ff @(posedge clock) begin
      if (reset || (step && end_of_text)) begin
         at_start_ff   <= 1'b1;
         negative_ff   <= 1'b0;
         frac_count_ff <= FC_NONE;
         digit_seen_ff <= 1'b0;
         whole_ff      <= '0;
         acc_ff        <= '0;
         cents_ff      <= '0;
         sticky_ff     <= 1'b0;
      end else begin
         at_start_ff   <= at_start_in;
         negative_ff   <= negative_in;
         frac_count_ff <= frac_count_in;
         digit_seen_ff <= digit_seen_in;
         whole_ff      <= whole_in;
         acc_ff        <= acc_in;
         cents_ff      <= cents_in;
         sticky_ff     <= sticky_in;
      end
   end

   // Form the result for an end marker
   assign cents_term = negative_ff ? 64'(-{57'd0, cents_ff}) : {57'd0, cents_ff};
   assign end_error  = sticky_ff || !digit_seen_ff || (whole_ff > WHOLE_LIMIT) ||
                       ((whole_ff == WHOLE_LIMIT) && (cents_ff != 7'd0));

   always_comb begin
      result.error  = end_error;
      result.amount = end_error ? '0 : $signed(acc_ff + cents_term);
   end

endmodule

`default_nettype wire

// ----- rtl/decimal_text_to_hundredths_top.sv -----
// ----------------------------------------------------------------------------
// decimal_text_to_hundredths_top: decimal amount text to signed hundredths
// Parses a stream of character beats closed by an end marker beat and
// returns the amount times 100, or an error flag, for each end marker.
// ----------------------------------------------------------------------------
//  channel  dir  ports              payload
//  req      in   req_t{valid,ready} tdata[7:0] char_code, tlast end_of_text
//  rsp      out  rsp_t{valid,ready} tdata[63:0] amount_hundredths,
//                                   tuser[0] parse_error
//
//  One beat per clock is taken. A beat is held in the input register; the
//  parser updates its state as it leaves that register. An end marker beat
//  loads its result into the output register as it leaves the input
//  register. Under a stalled rsp_tready the output register holds its result
//  and a following end marker waits in the input register with req_tready
//  low; character beats still flow while a result waits.
//  Synchronous reset clears all parse state and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_hundredths_top
   import dtth_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] char_code
   input  wire logic        req_tlast,    // end_of_text
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,    // [63:0] amount_hundredths
   output      logic [0:0]  rsp_tuser     // [0] parse_error
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_char_ff;
   logic            in_last_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     rsp_amount_ff;
   logic            rsp_error_ff;
   logic            out_free;
   logic            advance;
   dtth_result_type result;

   // Handshake between the stages
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_last_ff) || (rsp_valid_ff && !rsp_tready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   dtth_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .char_code   (in_char_ff),
      .end_of_text (in_last_ff),
      .result      (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_last_ff) begin
         rsp_amount_ff <= result.amount;
         rsp_error_ff  <= result.error;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_amount_ff;
   assign rsp_tuser[0] = rsp_error_ff;

   // Checks
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("error result carries a nonzero amount");

   a_end_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready |=> in_valid_ff && in_last_ff)
      else $error("end marker left the input register while the output stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register refused a beat");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff && in_last_ff))
      else $error("result appeared without an end marker");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for decimal_text_to_hundredths_top
// Streams amount text one character beat at a time, each string closed by an
// end marker beat. A directed table of short strings comes first, then random
// strings. Most are well formed; the rest are near the overflow limits,
// broken, or pure noise. Expected results come from a scoreboard model of the
// parser, or from the table where the answer is plain. Both sides idle and
// stall at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dtth_pkg::*;

   localparam int NUM_DIR    = 12;
   localparam int ITEM_GOAL  = 1150;
   localparam int FLOOD_AT   = 550;
   localparam int FLOOD_LEN  = 30;
   localparam int HOLD_LEN   = 300;
   localparam int DRAIN_WAIT = 20;
   localparam int CYCLE_CAP  = 300000;

   // One directed string: text right-aligned, first character in the highest used byte
   typedef struct packed {
      logic [47:0]        text;
      logic [3:0]         len;
      logic               typed;
      logic signed [63:0] amount;
      logic               error;
   } dir_row_type;

   // Known answer for a string, or a flag to use the parser model
   typedef struct packed {
      logic            typed;
      dtth_result_type res;
   } known_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   decimal_text_to_hundredths_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [7:0] char_code
      .req_tlast  (req_tlast),     // end_of_text
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [63:0] amount_hundredths
      .rsp_tuser  (rsp_tuser)      // [0] parse_error
   );

   always #1 clock = ~clock;

   // Parser model state
   logic        scan_start = 1'b1;
   logic        scan_neg   = 1'b0;
   logic [1:0]  scan_frac  = FC_NONE;
   logic        scan_digit = 1'b0;
   logic [63:0] scan_whole = '0;
   logic [6:0]  scan_cents = '0;
   logic        scan_bad   = 1'b0;

   dtth_result_type amount_q[$];   // expected results, oldest first
   known_type       known_q[$];    // one entry per end marker offered
   logic [7:0]      text_q[$];     // characters of the string being built
   dir_row_type     dir_table [NUM_DIR];

   int items_sent   = 0;
   int sent_markers = 0;
   int got_results  = 0;
   int fail_count   = 0;
   int cycle_count  = 0;
   int send_calm    = 0;
   bit flood        = 1'b0;

   // Fold one character into the model state
   function automatic void feed_char(input logic [7:0] c);
      logic first;
      first = scan_start;
      scan_start = 1'b0;
      if (scan_bad)
         return;
      if (first && c == CH_MINUS) begin
         scan_neg = 1'b1;
         return;
      end
      if (c == CH_POINT) begin
         if (scan_frac != FC_NONE)
            scan_bad = 1'b1;
         else
            scan_frac = FC_POINT;
         return;
      end
      if (c < CH_ZERO || c > CH_NINE) begin
         scan_bad = 1'b1;
         return;
      end
      scan_digit = 1'b1;
      if (scan_frac == FC_NONE) begin
         if (scan_whole > 64'(DIGIT_LIMIT))
            scan_bad = 1'b1;
         else
            scan_whole = scan_whole * 64'd10 + 64'(c - CH_ZERO);
      end else if (scan_frac == FC_TWO) begin
         scan_bad = 1'b1;
      end else begin
         scan_cents = scan_cents * 7'd10 + 7'(c - CH_ZERO);
         scan_frac  = scan_frac + 2'd1;
      end
   endfunction

   // Close the string: compute the amount and clear the model state
   function automatic dtth_result_type close_amount();
      logic [63:0]     cents;
      logic [63:0]     mag;
      logic            bad;
      dtth_result_type r;
      cents = 64'(scan_cents);
      if (scan_frac == FC_ONE)
         cents = cents * 64'd10;
      bad = scan_bad || !scan_digit || scan_whole > 64'(WHOLE_LIMIT) ||
            (scan_whole == 64'(WHOLE_LIMIT) && cents != 0);
      mag = scan_whole * 64'd100 + cents;
      r.error  = bad;
      r.amount = bad ? 64'sd0 : (scan_neg ? -$signed(mag) : $signed(mag));
      scan_start = 1'b1;
      scan_neg   = 1'b0;
      scan_frac  = FC_NONE;
      scan_digit = 1'b0;
      scan_whole = '0;
      scan_cents = '0;
      scan_bad   = 1'b0;
      return r;
   endfunction

   // Wait length for one beat; sometimes start a run of back-to-back beats
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // Offer one beat and hold it until accepted
   task automatic send_beat(input logic [7:0] c, input logic last);
      int gap;
      gap = flood ? 0 : draw_wait(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Send the built string and its end marker
   task automatic send_text(input logic typed, input dtth_result_type res);
      known_type k;
      foreach (text_q[i])
         send_beat(text_q[i], 1'b0);
      k.typed = typed;
      k.res   = res;
      known_q.push_back(k);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      sent_markers++;
   endtask

   // Hold the sender off until every expected result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (got_results != sent_markers) @(posedge clock);
   endtask

   task automatic put_digits(input int n);
      repeat (n) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic put_number(input logic [63:0] v);
      logic [7:0] rev[$];
      do begin
         rev.push_back(8'(64'(CH_ZERO) + v % 64'd10));
         v = v / 64'd10;
      end while (v != 0);
      while (rev.size() != 0)
         text_q.push_back(rev.pop_back());
   endtask

   // Sign, whole digits, optional point and up to two fraction digits
   task automatic build_well_formed();
      int nw;
      int nf;
      bit pt;
      nw = $urandom_range(0, 5);
      nf = $urandom_range(0, 2);
      pt = (nf > 0) || ($urandom_range(0, 3) == 0);
      if (nw == 0 && nf == 0)
         nw = 1;
      if ($urandom_range(0, 1))
         text_q.push_back(CH_MINUS);
      put_digits(nw);
      if (pt)
         text_q.push_back(CH_POINT);
      put_digits(nf);
   endtask

   // Whole parts around both overflow limits, with assorted fractions
   task automatic build_near_limit();
      logic [63:0] v;
      if ($urandom_range(0, 1))
         text_q.push_back(CH_MINUS);
      put_digits($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
      case ($urandom_range(0, 7))
         0: v = 64'(WHOLE_LIMIT);
         1: v = 64'(WHOLE_LIMIT) - 64'd1;
         2: v = 64'(WHOLE_LIMIT) + 64'd1;
         3: v = 64'(DIGIT_LIMIT);
         4: v = 64'(DIGIT_LIMIT) + 64'd1;
         5: v = 64'(DIGIT_LIMIT) * 64'd10 + 64'd9;
         6: v = (64'(DIGIT_LIMIT) + 64'd1) * 64'd10;
         default: v = {32'($urandom), 32'($urandom)};
      endcase
      put_number(v);
      case ($urandom_range(0, 5))
         0: ;
         1: text_q.push_back(CH_POINT);
         2: begin
            text_q.push_back(CH_POINT);
            text_q.push_back(CH_ZERO);
         end
         3: begin
            text_q.push_back(CH_POINT);
            put_digits(1);
         end
         4: begin
            text_q.push_back(CH_POINT);
            text_q.push_back(CH_ZERO);
            text_q.push_back(CH_ZERO);
         end
         default: begin
            text_q.push_back(CH_POINT);
            put_digits(2);
         end
      endcase
   endtask

   // A well-formed string with one defect put in
   task automatic build_broken();
      int pos;
      build_well_formed();
      pos = $urandom_range(0, text_q.size());
      case ($urandom_range(0, 3))
         0: text_q.insert(pos, 8'($urandom_range(0, 255)));
         1: text_q.insert(pos, CH_POINT);
         2: begin
            if (!(CH_POINT inside {text_q}))
               text_q.push_back(CH_POINT);
            put_digits($urandom_range(3, 4));
         end
         default: text_q.insert(pos == 0 ? 1 : pos, CH_MINUS);
      endcase
   endtask

   // Raw bytes, leaning on the characters the parser cares about
   task automatic build_noise();
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 7))
            0: text_q.push_back(CH_MINUS);
            1: text_q.push_back(CH_POINT);
            2: text_q.push_back(CH_ZERO);
            3: text_q.push_back(CH_NINE);
            default: text_q.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic build_random();
      int r;
      text_q.delete();
      r = $urandom_range(0, 99);
      if (r < 55)
         build_well_formed();
      else if (r < 67)
         build_near_limit();
      else if (r < 90)
         build_broken();
      else
         build_noise();
   endtask

   // Run length cap
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Track accepted input beats and check accepted results
   always @(posedge clock) begin
      dtth_result_type exp_res;
      known_type       k;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (req_tlast) begin
               exp_res = close_amount();
               if (known_q.size() != 0) begin
                  k = known_q.pop_front();
                  if (k.typed)
                     exp_res = k.res;
               end
               amount_q.push_back(exp_res);
            end else begin
               feed_char(req_tdata);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_results++;
            if (amount_q.size() == 0) begin
               $display("%0t: result with nothing expected: amount=%0d error=%0b",
                        $time, $signed(rsp_tdata), rsp_tuser[0]);
               fail_count++;
            end else begin
               exp_res = amount_q.pop_front();
               if (rsp_tdata !== exp_res.amount) begin
                  $display("%0t: amount mismatch: expected %0d, actual %0d",
                           $time, exp_res.amount, $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tuser[0] !== exp_res.error) begin
                  $display("%0t: error flag mismatch: expected %0b, actual %0b",
                           $time, exp_res.error, rsp_tuser[0]);
                  fail_count++;
               end
            end
         end
      end
   end

   // Result side: random stalls, one long hold-off while the input floods
   initial begin
      int  n;
      int  calm;
      bit  held;
      calm = 0;
      held = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         n = draw_wait(calm);
         if (flood && !held) begin
            held = 1'b1;
            n = HOLD_LEN;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Stimulus
   initial begin
      dtth_result_type res;
      bit              flood_done;
      int              len;
      flood_done = 1'b0;

      dir_table = '{
         '{48'h0,              4'd0, 1'b1,  64'sd0, 1'b1},  // empty text
         '{"-",                4'd1, 1'b1,  64'sd0, 1'b1},  // sign only
         '{".",                4'd1, 1'b1,  64'sd0, 1'b1},  // point only
         '{"-.",               4'd2, 1'b1,  64'sd0, 1'b1},  // sign and point
         '{"-0",               4'd2, 1'b1,  64'sd0, 1'b0},  // negative zero
         '{"..",               4'd2, 1'b1,  64'sd0, 1'b1},  // second point
         '{".123",             4'd4, 1'b1,  64'sd0, 1'b1},  // third fraction digit
         '{"5-",               4'd2, 1'b1,  64'sd0, 1'b1},  // minus not first
         '{{8'h00, "0"},       4'd2, 1'b1,  64'sd0, 1'b1},  // zero byte, digit ignored
         '{{8'hFF, "9"},       4'd2, 1'b1,  64'sd0, 1'b1},  // top byte, digit ignored
         '{"-9.9",             4'd4, 1'b0,  64'sd0, 1'b0},  // tenths, model checked
         '{"90",               4'd2, 1'b0,  64'sd0, 1'b0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings
      for (int i = 0; i < NUM_DIR; i++) begin
         text_q.delete();
         len = dir_table[i].len;
         for (int j = 0; j < len; j++)
            text_q.push_back(dir_table[i].text[8 * (len - 1 - j) +: 8]);
         res.amount = dir_table[i].amount;
         res.error  = dir_table[i].error;
         send_text(dir_table[i].typed, res);
      end
      drain();

      // Random strings, with one back-to-back flood against a stalled output
      res = '0;
      while (items_sent < ITEM_GOAL) begin
         if (!flood_done && items_sent >= FLOOD_AT) begin
            flood = 1'b1;
            repeat (FLOOD_LEN) begin
               text_q.delete();
               put_digits(1);
               send_text(1'b0, res);
            end
            flood = 1'b0;
            flood_done = 1'b1;
         end
         build_random();
         send_text(1'b0, res);
      end
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (amount_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, amount_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
